// ===== rtl/rau_pkg.sv =====
// Shared types, codes and widths of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

	localparam int RAU_WIDTH = 32;
	localparam int FLD_W     = 32;
	localparam int DVD_W     = 65;
	localparam int DVS_W     = 64;
	localparam int MUL_W     = 32;
	localparam int INT_W     = 33;
	localparam int CNT_W     = 7;
	localparam int S_DATA_W  = 136;
	localparam int M_DATA_W  = 104;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_MUL = 2'd1;
	localparam logic [1:0] OP_CMP = 2'd2;
	localparam logic [1:0] OP_CVT = 2'd3;

	localparam logic [1:0] ORD_LESS    = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OVF     = 2'd1;
	localparam logic [1:0] ST_ZERODEN = 2'd2;

	typedef struct packed {
		logic start;
		logic mul;
	} unit_req_t;

	typedef struct packed {
		logic done;
		logic busy;
	} unit_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer around the shared unit.
`timescale 1ns / 1ps
`default_nettype none
// Usage: one item on the slave stream carries an operation in s_tuser and two
// sign-magnitude fractions in s_tdata. Each item gives exactly one result item
// on the master stream: a reduced fraction for add and multiply, an order code
// for compare, a truncated integer for convert, plus a status code.
// The block works on one item at a time. s_tready is high only while the
// sequencer is idle; an item is then held while every divide, remainder and
// multiply step runs on one shared bit-serial unit. Add runs two Euclid gcd
// passes and multiply one; compare and convert run none. A zero denominator
// skips the unit entirely. The next item is taken in the idle state.
// A finished result sits in an output register; the next item is taken while
// it waits. If the receiver stalls, the next result is held in the sequencer
// until the output register frees up, and no further item is accepted.
// Reset clears the sequencer and the output valid; no result is pending after it.
// WIDTH sets the overflow limit of the reduced numerator and denominator.
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int WIDTH = RAU_WIDTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// a_num, a_den, a_neg, b_num, b_den, b_neg, zero fill
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// operation
	input  wire logic [1:0]          s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// res_num, res_den, res_neg, order, int_value, status, zero fill
	output logic [M_DATA_W-1:0]      m_tdata
);

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_GCD, S_DIVA, S_DIVB, S_LCM, S_XA, S_XB, S_SUM,
		S_EREM, S_EQ, S_ERD, S_EFIN, S_MUL1, S_MUL2, S_CM1, S_CM2, S_CMPF,
		S_CVT, S_OUT
	} state_t;

	state_t state_q;
	logic   iss_q, gret_q;

	logic [1:0]       op_q;
	logic [FLD_W-1:0] an_q, ad_q, bn_q, bd_q;
	logic             aneg_q, bneg_q, neg_q;
	logic [DVS_W-1:0] x_q, y_q, t1_q, t2_q, den_q, xa_q, xb_q;
	logic [DVD_W-1:0] num_q, q_q;

	logic [FLD_W-1:0] rs_num_q, rs_den_q;
	logic             rs_neg_q;
	logic [1:0]       rs_ord_q, rs_st_q;
	logic [INT_W-1:0] rs_int_q;

	logic             ov_q;
	logic [FLD_W-1:0] o_num_q, o_den_q;
	logic             o_neg_q;
	logic [1:0]       o_ord_q, o_st_q;
	logic [INT_W-1:0] o_int_q;

	unit_req_t        req;
	unit_rsp_t        rsp;
	logic [DVD_W-1:0] opa, quo;
	logic [DVS_W-1:0] opb, rem;
	logic             unit_state;
	logic             done;

	logic [DVD_W-1:0] sum;
	logic             sa, sb;
	logic [1:0]       ord;
	logic             ovf;

	rau_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.rsp    (rsp),
		.quo    (quo),
		.rem    (rem)
	);

	// Operand selection for the shared unit, one operation per sequencer state.
	always_comb begin
		opa        = '0;
		opb        = '0;
		req.mul    = 1'b0;
		unit_state = 1'b1;
		case (state_q)
			S_GCD: begin
				opa = {1'b0, x_q};
				opb = y_q;
			end
			S_DIVA: begin
				opa = {33'b0, ad_q};
				opb = x_q;
			end
			S_DIVB: begin
				opa = {33'b0, bd_q};
				opb = x_q;
			end
			S_LCM: begin
				opa = {1'b0, t1_q};
				opb = {32'b0, bd_q};
				req.mul = 1'b1;
			end
			S_XA: begin
				opa = {33'b0, an_q};
				opb = t2_q;
				req.mul = 1'b1;
			end
			S_XB: begin
				opa = {33'b0, bn_q};
				opb = t1_q;
				req.mul = 1'b1;
			end
			S_EREM: begin
				opa = num_q;
				opb = den_q;
			end
			S_EQ: begin
				opa = num_q;
				opb = x_q;
			end
			S_ERD: begin
				opa = {1'b0, den_q};
				opb = x_q;
			end
			S_MUL1: begin
				opa = {33'b0, an_q};
				opb = {32'b0, bn_q};
				req.mul = 1'b1;
			end
			S_MUL2: begin
				opa = {33'b0, ad_q};
				opb = {32'b0, bd_q};
				req.mul = 1'b1;
			end
			S_CM1: begin
				opa = {33'b0, an_q};
				opb = {32'b0, bd_q};
				req.mul = 1'b1;
			end
			S_CM2: begin
				opa = {33'b0, bn_q};
				opb = {32'b0, ad_q};
				req.mul = 1'b1;
			end
			S_CVT: begin
				opa = {33'b0, an_q};
				opb = {32'b0, ad_q};
			end
			default: unit_state = 1'b0;
		endcase
		// The gcd loop stops issuing once the remainder reaches zero.
		req.start = unit_state && !iss_q && !(state_q == S_GCD && y_q == '0);
	end

	assign done = iss_q && rsp.done;

	// Sign handling for add: the larger scaled magnitude sets the sign; a tie keeps a's sign.
	assign sum = {1'b0, xa_q} + {1'b0, xb_q};

	// Signed order; a zero numerator counts as zero whatever its sign bit.
	always_comb begin
		sa = aneg_q && an_q != '0;
		sb = bneg_q && bn_q != '0;
		if (sa != sb)
			ord = sa ? ORD_LESS : ORD_GREATER;
		else if (xa_q == xb_q)
			ord = ORD_EQUAL;
		else if ((xa_q < xb_q) != sa)
			ord = ORD_LESS;
		else
			ord = ORD_GREATER;
	end

	assign ovf = q_q[DVD_W-1] || ((q_q[DVS_W-1:0] >> WIDTH) != '0) ||
		((t1_q >> WIDTH) != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iss_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (req.start)
				iss_q <= 1'b1;
			else if (done)
				iss_q <= 1'b0;
			if (m_tvalid && m_tready)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						an_q    <= s_tdata[31:0];
						ad_q    <= s_tdata[63:32];
						aneg_q  <= s_tdata[64];
						bn_q    <= s_tdata[96:65];
						bd_q    <= s_tdata[128:97];
						bneg_q  <= s_tdata[129];
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					rs_num_q <= '0;
					rs_den_q <= '0;
					rs_neg_q <= 1'b0;
					rs_ord_q <= ORD_LESS;
					rs_int_q <= '0;
					rs_st_q  <= ST_OK;
					if (op_q == OP_CVT) begin
						if (ad_q == '0) begin
							rs_st_q <= ST_ZERODEN;
							state_q <= S_OUT;
						end else begin
							state_q <= S_CVT;
						end
					end else if (ad_q == '0 || bd_q == '0) begin
						rs_st_q <= ST_ZERODEN;
						state_q <= S_OUT;
					end else if (op_q == OP_ADD) begin
						x_q     <= {32'b0, ad_q};
						y_q     <= {32'b0, bd_q};
						gret_q  <= 1'b0;
						state_q <= S_GCD;
					end else if (op_q == OP_MUL) begin
						neg_q   <= aneg_q ^ bneg_q;
						state_q <= S_MUL1;
					end else begin
						state_q <= S_CM1;
					end
				end
				S_GCD: begin
					if (y_q == '0)
						state_q <= gret_q ? S_EQ : S_DIVA;
					else if (done) begin
						x_q <= y_q;
						y_q <= rem;
					end
				end
				S_DIVA: if (done) begin
					t1_q    <= quo[DVS_W-1:0];
					state_q <= S_DIVB;
				end
				S_DIVB: if (done) begin
					t2_q    <= quo[DVS_W-1:0];
					state_q <= S_LCM;
				end
				S_LCM: if (done) begin
					den_q   <= quo[DVS_W-1:0];
					state_q <= S_XA;
				end
				S_XA: if (done) begin
					xa_q    <= quo[DVS_W-1:0];
					state_q <= S_XB;
				end
				S_XB: if (done) begin
					xb_q    <= quo[DVS_W-1:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (aneg_q == bneg_q) begin
						num_q <= sum;
						neg_q <= aneg_q;
					end else if (xb_q > xa_q) begin
						num_q <= {1'b0, xb_q - xa_q};
						neg_q <= bneg_q;
					end else begin
						num_q <= {1'b0, xa_q - xb_q};
						neg_q <= aneg_q;
					end
					state_q <= S_EREM;
				end
				S_EREM: if (done) begin
					x_q     <= den_q;
					y_q     <= rem;
					gret_q  <= 1'b1;
					state_q <= S_GCD;
				end
				S_EQ: if (done) begin
					q_q     <= quo;
					state_q <= S_ERD;
				end
				S_ERD: if (done) begin
					t1_q    <= quo[DVS_W-1:0];
					state_q <= S_EFIN;
				end
				S_EFIN: begin
					if (ovf) begin
						rs_st_q <= ST_OVF;
					end else begin
						rs_num_q <= q_q[FLD_W-1:0];
						rs_den_q <= t1_q[FLD_W-1:0];
						rs_neg_q <= neg_q;
					end
					state_q <= S_OUT;
				end
				S_MUL1: if (done) begin
					num_q   <= {1'b0, quo[DVS_W-1:0]};
					state_q <= S_MUL2;
				end
				S_MUL2: if (done) begin
					den_q   <= quo[DVS_W-1:0];
					state_q <= S_EREM;
				end
				S_CM1: if (done) begin
					xa_q    <= quo[DVS_W-1:0];
					state_q <= S_CM2;
				end
				S_CM2: if (done) begin
					xb_q    <= quo[DVS_W-1:0];
					state_q <= S_CMPF;
				end
				S_CMPF: begin
					rs_ord_q <= ord;
					state_q  <= S_OUT;
				end
				S_CVT: if (done) begin
					rs_int_q <= aneg_q ? (INT_W'(0) - quo[INT_W-1:0]) : quo[INT_W-1:0];
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (!ov_q || m_tready) begin
						ov_q    <= 1'b1;
						o_num_q <= rs_num_q;
						o_den_q <= rs_den_q;
						o_neg_q <= rs_neg_q;
						o_ord_q <= rs_ord_q;
						o_int_q <= rs_int_q;
						o_st_q  <= rs_st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = ov_q;
	assign m_tdata  = {2'b0, o_st_q, o_int_q, o_ord_q, o_neg_q, o_den_q, o_num_q};

endmodule
`default_nettype wire

// ===== rtl/rau_unit.sv =====
// Shared bit-serial unit: 65 by 64 bit divide or 32 by 32 bit multiply.
`timescale 1ns / 1ps
`default_nettype none
module rau_unit
	import rau_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire unit_req_t        req,
	input  wire logic [DVD_W-1:0] opa,
	input  wire logic [DVS_W-1:0] opb,
	output unit_rsp_t             rsp,
	output logic      [DVD_W-1:0] quo,
	output logic      [DVS_W-1:0] rem
);

	logic             busy_q, done_q, mul_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] n_q;
	logic [DVS_W-1:0] r_q, d_q;
	logic [DVD_W-1:0] trial, diff;
	logic             ge;

	// One restoring division step: shift the next dividend bit into the remainder.
	assign trial = {r_q, n_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mul_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				mul_q  <= req.mul;
				r_q    <= '0;
				if (req.mul) begin
					cnt_q <= CNT_W'(MUL_W);
					n_q   <= {{(DVD_W-MUL_W){1'b0}}, opb[MUL_W-1:0]};
					d_q   <= {{(DVS_W-MUL_W){1'b0}}, opa[MUL_W-1:0]};
				end else begin
					cnt_q <= CNT_W'(DVD_W);
					n_q   <= opa;
					d_q   <= opb;
				end
			end else if (busy_q) begin
				if (mul_q) begin
					if (n_q[0])
						r_q <= r_q + d_q;
					d_q <= {d_q[DVS_W-2:0], 1'b0};
					n_q <= {1'b0, n_q[DVD_W-1:1]};
				end else begin
					r_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
					n_q <= {n_q[DVD_W-2:0], ge};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign quo      = mul_q ? {1'b0, r_q} : n_q;
	assign rem      = r_q;

endmodule
`default_nettype wire

// ===== rtl/rau_checker.sv =====
// Port-level assertions for the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rau_checker
	import rau_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [S_DATA_W-1:0] s_tdata,
	input wire logic [1:0]          s_tuser,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[101:100] != 2'd3)
		else $error("undefined status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[101:100] != ST_OK |-> m_tdata[99:0] == '0)
		else $error("error result carries nonzero fields");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
`default_nettype wire

// ===== verif/tb_rational_arithmetic_unit.sv =====
// Self-checking testbench of the rational arithmetic unit with a built-in fraction predictor.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
	import rau_pkg::*;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic        a_neg;
		logic [31:0] b_num;
		logic [31:0] b_den;
		logic        b_neg;
	} rat_req_t;

	typedef struct packed {
		logic [31:0] res_num;
		logic [31:0] res_den;
		logic        res_neg;
		logic [1:0]  order;
		logic [32:0] int_value;
		logic [1:0]  status;
	} rat_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = OP_ADD;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	rat_req_t pending_q[$];
	rat_res_t expected_q[$];
	int error_count = 0;
	bit stimulus_done = 1'b0;
	int src_gap = 0;
	int sink_gap = 0;

	rational_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = y;
			y = x % y;
			x = t;
		end
		return x;
	endfunction

	// Reduce a 65-bit numerator over a 64-bit denominator and apply the width check.
	function automatic rat_res_t reduce_fraction(logic [64:0] num, logic [63:0] den,
			logic neg);
		rat_res_t r;
		logic [63:0] rem, m;
		logic [64:0] q;
		logic [63:0] rd;
		r = '0;
		rem = 64'(num % {1'b0, den});
		m = gcd64(den, rem);
		q = num / {1'b0, m};
		rd = den / m;
		if (q[64] || (q[63:0] >> (RAU_WIDTH - 1)) >> 1 != 0 || (rd >> (RAU_WIDTH - 1)) >> 1 != 0)
			r.status = ST_OVF;
		else begin
			r.res_num = q[31:0];
			r.res_den = rd[31:0];
			r.res_neg = neg;
		end
		return r;
	endfunction

	function automatic rat_res_t predict_rational(rat_req_t it);
		rat_res_t r;
		logic [63:0] g, lcm, xa, xb, ma, mb;
		logic [64:0] sum;
		logic neg, sa, sb;
		logic [1:0] ord;
		r = '0;
		if (it.op == OP_CVT) begin
			if (it.a_den == 0) r.status = ST_ZERODEN;
			else begin
				xa = {32'd0, it.a_num / it.a_den};
				r.int_value = it.a_neg ? 33'(-xa) : xa[32:0];
			end
			return r;
		end
		if (it.a_den == 0 || it.b_den == 0) begin
			r.status = ST_ZERODEN;
			return r;
		end
		case (it.op)
			OP_ADD: begin
				g = gcd64({32'd0, it.a_den}, {32'd0, it.b_den});
				lcm = ({32'd0, it.a_den} / g) * it.b_den;
				xa = it.a_num * ({32'd0, it.b_den} / g);
				xb = it.b_num * ({32'd0, it.a_den} / g);
				neg = it.a_neg;
				if (it.a_neg == it.b_neg) sum = {1'b0, xa} + {1'b0, xb};
				else if (xb > xa) begin
					sum = {1'b0, xb - xa};
					neg = it.b_neg;
				end else sum = {1'b0, xa - xb};
				r = reduce_fraction(sum, lcm, neg);
			end
			OP_MUL: r = reduce_fraction({1'b0, 64'(it.a_num) * it.b_num},
				64'(it.a_den) * it.b_den, it.a_neg ^ it.b_neg);
			default: begin
				sa = it.a_neg && it.a_num != 0;
				sb = it.b_neg && it.b_num != 0;
				ma = 64'(it.a_num) * it.b_den;
				mb = 64'(it.b_num) * it.a_den;
				if (sa != sb) ord = sa ? ORD_LESS : ORD_GREATER;
				else begin
					ord = ma < mb ? ORD_LESS : ma > mb ? ORD_GREATER : ORD_EQUAL;
					if (sa && ord != ORD_EQUAL) ord = ORD_GREATER - ord;
				end
				r.order = ord;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Mixed-scale operand: mostly small, sometimes extreme.
	function automatic logic [31:0] pick_value(bit allow_zero);
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 15);
			1: v = $urandom_range(0, 1000);
			2: v = $urandom_range(0, 65535);
			3: v = $urandom;
			4: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: v = 32'd1 << $urandom_range(0, 31);
		endcase
		if (!allow_zero && v == 0) v = 1;
		return v;
	endfunction

	task automatic queue_item(logic [1:0] op, logic [31:0] an, logic [31:0] ad, logic aneg,
			logic [31:0] bn, logic [31:0] bd, logic bneg);
		pending_q.push_back('{op, an, ad, aneg, bn, bd, bneg});
	endtask

	// Driver: the current item stays on the bus until it is taken.
	always @(posedge clk) begin
		rat_req_t it;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_q.push_back(predict_rational(pending_q.pop_front()));
				src_gap = pick_gap();
			end
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				it = pending_q[0];
				s_tvalid <= 1'b1;
				s_tuser <= it.op;
				s_tdata <= {6'd0, it.b_neg, it.b_den, it.b_num, it.a_neg, it.a_den, it.a_num};
			end else s_tvalid <= 1'b0;
		end
	end

	// Monitor: check each accepted result and pick the next ready pattern.
	always @(posedge clk) begin
		rat_res_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.res_num = m_tdata[31:0];
				got.res_den = m_tdata[63:32];
				got.res_neg = m_tdata[64];
				got.order = m_tdata[66:65];
				got.int_value = m_tdata[99:67];
				got.status = m_tdata[101:100];
				if (expected_q.size() == 0) report_mismatch("unexpected result", 0, 0);
				else begin
					want = expected_q.pop_front();
					if (got.res_num != want.res_num)
						report_mismatch("res_num", got.res_num, want.res_num);
					if (got.res_den != want.res_den)
						report_mismatch("res_den", got.res_den, want.res_den);
					if (got.res_neg != want.res_neg)
						report_mismatch("res_neg", got.res_neg, want.res_neg);
					if (got.order != want.order) report_mismatch("order", got.order, want.order);
					if (got.int_value != want.int_value)
						report_mismatch("int_value", got.int_value, want.int_value);
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_gap = pick_gap();
			end
		end
	end

	initial begin
		// Directed: extremes, every operation, zero denominators, signed zeros, overflow.
		queue_item(OP_ADD, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3, 1'b0);
		queue_item(OP_ADD, 32'd1, 32'd2, 1'b1, 32'd1, 32'd2, 1'b0);
		queue_item(OP_ADD, 32'd0, 32'd5, 1'b1, 32'd0, 32'd7, 1'b1);
		queue_item(OP_ADD, 32'd3, 32'd4, 1'b0, 32'd5, 32'd4, 1'b1);
		queue_item(OP_ADD, '1, '1, 1'b0, '1, 32'd1, 1'b0);
		queue_item(OP_ADD, '1, 32'd1, 1'b1, '1, 32'd1, 1'b1);
		queue_item(OP_ADD, 32'd1, '1, 1'b0, 32'd1, 32'hFFFF_FFFE, 1'b0);
		queue_item(OP_ADD, 32'd1, 32'd0, 1'b0, 32'd1, 32'd1, 1'b0);
		queue_item(OP_MUL, 32'd6, 32'd4, 1'b1, 32'd2, 32'd3, 1'b0);
		queue_item(OP_MUL, '1, 32'd1, 1'b0, '1, 32'd1, 1'b1);
		queue_item(OP_MUL, 32'd0, '1, 1'b1, '1, '1, 1'b1);
		queue_item(OP_MUL, '1, '1, 1'b1, '1, '1, 1'b1);
		queue_item(OP_MUL, 32'd1, 32'd1, 1'b0, 32'd1, 32'd0, 1'b0);
		queue_item(OP_CMP, 32'd0, 32'd3, 1'b1, 32'd0, 32'd9, 1'b0);
		queue_item(OP_CMP, 32'd1, 32'd2, 1'b1, 32'd1, 32'd3, 1'b1);
		queue_item(OP_CMP, 32'd2, 32'd4, 1'b0, 32'd1, 32'd2, 1'b0);
		queue_item(OP_CMP, '1, 32'd1, 1'b0, '1, '1, 1'b1);
		queue_item(OP_CMP, 32'd1, 32'd1, 1'b0, 32'd1, 32'd0, 1'b0);
		queue_item(OP_CVT, '1, 32'd1, 1'b1, 32'd0, 32'd0, 1'b0);
		queue_item(OP_CVT, 32'd7, 32'd2, 1'b1, 32'd0, 32'd0, 1'b1);
		queue_item(OP_CVT, 32'd0, 32'd5, 1'b1, '1, '1, 1'b0);
		queue_item(OP_CVT, '1, 32'd1, 1'b0, '1, '1, 1'b1);
		queue_item(OP_CVT, 32'd5, 32'd0, 1'b0, 32'd1, 32'd1, 1'b0);
		for (int i = 0; i < 1500; i++) begin
			queue_item(2'($urandom_range(0, 3)), pick_value(1'b1),
				($urandom_range(0, 39) == 0) ? 32'd0 : pick_value(1'b0), 1'($urandom),
				pick_value(1'b1),
				($urandom_range(0, 39) == 0) ? 32'd0 : pick_value(1'b0), 1'($urandom));
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_q.size() == 0);
		wait (expected_q.size() == 0);
		repeat (300) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// The timeout leaves room for the longest gcd passes and long stalls.
	initial begin
		#1000ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/rau_pkg.sv
rtl/rau_unit.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
verif/tb_rational_arithmetic_unit.sv
